>>> rtl/core/mi3_pkg.sv
// ---------------------------------------------------------------------------
// mi3_pkg: shared constants for the 3x3 matrix inverse
// Default formats, epsilon register layout and cofactor index tables.
// ---------------------------------------------------------------------------
package mi3_pkg;

	localparam int unsigned DATA_WIDTH_DEF = 32;
	localparam int unsigned FRAC_BITS_DEF  = 16;

	// singular epsilon register
	localparam int unsigned EPS_W = 31;
	localparam logic [EPS_W-1:0] EPS_RESET = 31'd7;

	// element index, row major
	typedef logic [3:0] idx_t;

	// cofactor k = a[P0]*a[P1] - a[Q0]*a[Q1]
	localparam idx_t CF_P0 [9] = '{4'd4, 4'd5, 4'd3, 4'd2, 4'd0, 4'd1, 4'd1, 4'd2, 4'd0};
	localparam idx_t CF_P1 [9] = '{4'd8, 4'd6, 4'd7, 4'd7, 4'd8, 4'd6, 4'd5, 4'd3, 4'd4};
	localparam idx_t CF_Q0 [9] = '{4'd5, 4'd3, 4'd4, 4'd1, 4'd2, 4'd0, 4'd2, 4'd0, 4'd1};
	localparam idx_t CF_Q1 [9] = '{4'd7, 4'd8, 4'd6, 4'd8, 4'd6, 4'd7, 4'd4, 4'd5, 4'd3};

	// inverse element k = i*3+j takes cofactor j*3+i
	localparam idx_t INV_SRC [9] = '{4'd0, 4'd3, 4'd6, 4'd1, 4'd4, 4'd7, 4'd2, 4'd5, 4'd8};

endpackage

>>> rtl/core/mi3_if.sv
// ---------------------------------------------------------------------------
// mi3_if: handshake channels of the 3x3 matrix inverse
// Matrix channel in, result channel out; valid/ready with payload.
// ---------------------------------------------------------------------------
interface mi3_mat_if import mi3_pkg::*; #(
	parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
);
	logic valid;
	logic ready;
	logic signed [DATA_WIDTH-1:0] a_r0c0;
	logic signed [DATA_WIDTH-1:0] a_r0c1;
	logic signed [DATA_WIDTH-1:0] a_r0c2;
	logic signed [DATA_WIDTH-1:0] a_r1c0;
	logic signed [DATA_WIDTH-1:0] a_r1c1;
	logic signed [DATA_WIDTH-1:0] a_r1c2;
	logic signed [DATA_WIDTH-1:0] a_r2c0;
	logic signed [DATA_WIDTH-1:0] a_r2c1;
	logic signed [DATA_WIDTH-1:0] a_r2c2;

	modport source (output valid, a_r0c0, a_r0c1, a_r0c2, a_r1c0, a_r1c1, a_r1c2,
		a_r2c0, a_r2c1, a_r2c2, input ready);
	modport sink (input valid, a_r0c0, a_r0c1, a_r0c2, a_r1c0, a_r1c1, a_r1c2,
		a_r2c0, a_r2c1, a_r2c2, output ready);
endinterface

interface mi3_res_if import mi3_pkg::*; #(
	parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
);
	logic valid;
	logic ready;
	logic signed [DATA_WIDTH-1:0] inv_r0c0;
	logic signed [DATA_WIDTH-1:0] inv_r0c1;
	logic signed [DATA_WIDTH-1:0] inv_r0c2;
	logic signed [DATA_WIDTH-1:0] inv_r1c0;
	logic signed [DATA_WIDTH-1:0] inv_r1c1;
	logic signed [DATA_WIDTH-1:0] inv_r1c2;
	logic signed [DATA_WIDTH-1:0] inv_r2c0;
	logic signed [DATA_WIDTH-1:0] inv_r2c1;
	logic signed [DATA_WIDTH-1:0] inv_r2c2;
	logic signed [DATA_WIDTH-1:0] determinant;
	logic singular;

	modport source (output valid, inv_r0c0, inv_r0c1, inv_r0c2, inv_r1c0, inv_r1c1,
		inv_r1c2, inv_r2c0, inv_r2c1, inv_r2c2, determinant, singular, input ready);
	modport sink (input valid, inv_r0c0, inv_r0c1, inv_r0c2, inv_r1c0, inv_r1c1,
		inv_r1c2, inv_r2c0, inv_r2c1, inv_r2c2, determinant, singular, output ready);
endinterface

>>> rtl/core/matrix3x3_inverse.sv
// ---------------------------------------------------------------------------
// matrix3x3_inverse: pipelined inverse of a signed fixed-point 3x3 matrix
// Cofactors, determinant, singular test and nine parallel long divisions.
// ---------------------------------------------------------------------------
// The block takes one matrix item per clock and gives one result item per
// clock. A matrix passes through six stages of multiply, round and setup
// (default format Q16.16), then one restoring-division stage for each of
// the DATA_WIDTH + FRAC_BITS + 1 quotient bits, then the output register.
// The whole pipeline halts while a result waits at the output. A
// determinant whose magnitude is below the epsilon register (or zero)
// sets singular and gives zero inverse elements; the determinant is
// reported in every case.
// ---------------------------------------------------------------------------
module matrix3x3_inverse import mi3_pkg::*; #(
	parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF,
	parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             eps_we,
	input  logic [EPS_W-1:0] eps_wdata,
	mi3_mat_if.sink          mat,
	mi3_res_if.source        res
);

	localparam int unsigned W  = DATA_WIDTH;
	localparam int unsigned F  = FRAC_BITS;
	localparam int unsigned PW = 2 * W;
	localparam int unsigned SW = 2 * W + 2;
	localparam int unsigned NW = W + F + 1;
	localparam int unsigned RW = W + 1;
	localparam int unsigned CW = (W > EPS_W) ? W : EPS_W;

	localparam logic signed [SW-1:0] S_HALF = SW'(1) <<< (F - 1);
	localparam logic signed [SW-1:0] S_MAX  = (SW'(1) <<< (W - 1)) - SW'(1);
	localparam logic signed [SW-1:0] S_MIN  = -(SW'(1) <<< (W - 1));
	localparam logic [NW-1:0] Q_MAX = (NW'(1) << (W - 1)) - NW'(1);
	localparam logic [NW-1:0] Q_MIN = NW'(1) << (W - 1);
	localparam logic [W-1:0]  D_MAX = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0]  D_MIN = {1'b1, {(W-1){1'b0}}};

	// round to nearest (ties up), shift out the fraction, saturate
	function automatic logic signed [W-1:0] rsat(input logic signed [SW-1:0] x);
		logic signed [SW-1:0] s;
		s = (x + S_HALF) >>> F;
		if (s > S_MAX) begin
			return D_MAX;
		end else if (s < S_MIN) begin
			return D_MIN;
		end
		return s[W-1:0];
	endfunction

	function automatic logic [W-1:0] mag(input logic [W-1:0] x);
		return x[W-1] ? (~x + W'(1)) : x;
	endfunction

	logic en;
	logic [EPS_W-1:0] eps_q;

	logic signed [W-1:0]  a_in [9];
	logic                 v_s1, v_s2, v_s3, v_s4, v_s5;
	logic signed [W-1:0]  a_s1 [9];
	logic signed [PW-1:0] mp_s2 [9];
	logic signed [PW-1:0] mq_s2 [9];
	logic signed [W-1:0]  a_s2 [3];
	logic signed [W-1:0]  c_s3 [9];
	logic signed [W-1:0]  a_s3 [3];
	logic signed [PW-1:0] dp_s4 [3];
	logic signed [W-1:0]  c_s4 [9];
	logic signed [W-1:0]  c_s5 [9];
	logic signed [W-1:0]  det_s5;

	// division pipeline, stage 0 is the setup register
	logic          v_d    [NW+1];
	logic          sing_d [NW+1];
	logic [W-1:0]  det_d  [NW+1];
	logic [RW-1:0] d2_d   [NW+1];
	logic [8:0]    neg_d  [NW+1];
	logic [RW-1:0] rem_d  [NW+1][9];
	logic [NW-1:0] num_d  [NW+1][9];

	logic          res_valid_q;
	logic [W-1:0]  inv_q [9];
	logic [W-1:0]  det_q;
	logic          sing_q;

	// halt every stage while a result waits
	assign en        = !res_valid_q || res.ready;
	assign mat.ready = en;

	// singular epsilon register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= EPS_RESET;
		end else if (eps_we) begin
			eps_q <= eps_wdata;
		end
	end

	assign a_in[0] = mat.a_r0c0;
	assign a_in[1] = mat.a_r0c1;
	assign a_in[2] = mat.a_r0c2;
	assign a_in[3] = mat.a_r1c0;
	assign a_in[4] = mat.a_r1c1;
	assign a_in[5] = mat.a_r1c2;
	assign a_in[6] = mat.a_r2c0;
	assign a_in[7] = mat.a_r2c1;
	assign a_in[8] = mat.a_r2c2;

	// advance valid bits of the front stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			v_s5    <= 1'b0;
			v_d[0]  <= 1'b0;
		end else if (en) begin
			v_s1    <= mat.valid;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			v_s4    <= v_s3;
			v_s5    <= v_s4;
			v_d[0]  <= v_s5;
		end
	end

	// front stages: capture, minor products, cofactors, row products, determinant
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 9; k++) begin
				a_s1[k]  <= a_in[k];
				mp_s2[k] <= a_s1[CF_P0[k]] * a_s1[CF_P1[k]];
				mq_s2[k] <= a_s1[CF_Q0[k]] * a_s1[CF_Q1[k]];
				c_s3[k]  <= rsat(SW'(mp_s2[k]) - SW'(mq_s2[k]));
				c_s4[k]  <= c_s3[k];
				c_s5[k]  <= c_s4[k];
			end
			for (int k = 0; k < 3; k++) begin
				a_s2[k]  <= a_s1[k];
				a_s3[k]  <= a_s2[k];
				dp_s4[k] <= a_s3[k] * c_s3[k];
			end
			det_s5 <= rsat(SW'(dp_s4[0]) + SW'(dp_s4[1]) + SW'(dp_s4[2]));
		end
	end

	// division setup: dividend 2|c|*2^F + |det|, divisor 2|det|
	always_ff @(posedge clk) begin
		if (en) begin
			sing_d[0] <= (det_s5 == '0) || (CW'(mag(det_s5)) < CW'(eps_q));
			det_d[0]  <= det_s5;
			d2_d[0]   <= {mag(det_s5), 1'b0};
			for (int k = 0; k < 9; k++) begin
				neg_d[0][k]  <= c_s5[INV_SRC[k]][W-1] ^ det_s5[W-1];
				rem_d[0][k]  <= '0;
				num_d[0][k]  <= (NW'(mag(c_s5[INV_SRC[k]])) << (F + 1)) + NW'(mag(det_s5));
			end
		end
	end

	// one quotient bit per stage in each of the nine lanes
	for (genvar j = 1; j <= NW; j++) begin : g_div
		logic [RW:0]   t   [9];
		logic [8:0]    ge;
		logic [RW-1:0] rn  [9];

		always_comb begin
			for (int k = 0; k < 9; k++) begin
				t[k]  = {rem_d[j-1][k], num_d[j-1][k][NW-1]};
				ge[k] = t[k] >= {1'b0, d2_d[j-1]};
				rn[k] = ge[k] ? RW'(t[k] - {1'b0, d2_d[j-1]}) : RW'(t[k]);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_d[j] <= 1'b0;
			end else if (en) begin
				v_d[j] <= v_d[j-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sing_d[j] <= sing_d[j-1];
				det_d[j]  <= det_d[j-1];
				d2_d[j]   <= d2_d[j-1];
				neg_d[j]  <= neg_d[j-1];
				for (int k = 0; k < 9; k++) begin
					rem_d[j][k] <= rn[k];
					num_d[j][k] <= {num_d[j-1][k][NW-2:0], ge[k]};
				end
			end
		end
	end

	// output register: sign, saturate, zero when singular
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (en) begin
			res_valid_q <= v_d[NW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			det_q  <= det_d[NW];
			sing_q <= sing_d[NW];
			for (int k = 0; k < 9; k++) begin
				if (sing_d[NW]) begin
					inv_q[k] <= '0;
				end else if (!neg_d[NW][k]) begin
					inv_q[k] <= (num_d[NW][k] > Q_MAX) ? D_MAX : num_d[NW][k][W-1:0];
				end else begin
					inv_q[k] <= (num_d[NW][k] > Q_MIN) ? D_MIN : (~num_d[NW][k][W-1:0] + W'(1));
				end
			end
		end
	end

	assign res.valid       = res_valid_q;
	assign res.inv_r0c0    = inv_q[0];
	assign res.inv_r0c1    = inv_q[1];
	assign res.inv_r0c2    = inv_q[2];
	assign res.inv_r1c0    = inv_q[3];
	assign res.inv_r1c1    = inv_q[4];
	assign res.inv_r1c2    = inv_q[5];
	assign res.inv_r2c0    = inv_q[6];
	assign res.inv_r2c1    = inv_q[7];
	assign res.inv_r2c2    = inv_q[8];
	assign res.determinant = det_q;
	assign res.singular    = sing_q;

endmodule

>>> dv/tb_matrix3x3_inverse.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_matrix3x3_inverse: self-checking bench for the 3x3 matrix inverse
// Streams directed and random matrices through the block under several
// epsilon settings, with random input gaps and random result stalls. A
// scoreboard works out each expected inverse in exact wide arithmetic and
// checks every result field in arrival order.
// ---------------------------------------------------------------------------
module tb_matrix3x3_inverse import mi3_pkg::*;;

	localparam int DW        = 32;
	localparam int FB        = 16;
	localparam int LATENCY   = DW + FB + 7;
	localparam int WDOG_MAX  = 20000;
	localparam int N_RANDOM  = 2000;

	typedef logic signed [DW-1:0] q_t;
	typedef logic signed [127:0] wide_t;

	typedef struct {
		q_t e[9];
	} matrix_t;

	typedef struct {
		q_t     inv[9];
		q_t     det;
		logic   sing;
	} inverse_t;

	// Exact predictor and in-order store of expected inverses
	class inverse_scoreboard;
		logic [EPS_W-1:0] eps;
		inverse_t         pending[$];
		int               n_err;

		function new();
			eps   = EPS_RESET;
			n_err = 0;
		endfunction

		function q_t clamp(wide_t x);
			wide_t hi, lo;
			hi = (wide_t'(1) <<< (DW-1)) - 1;
			lo = -(wide_t'(1) <<< (DW-1));
			if (x > hi) return q_t'(hi);
			if (x < lo) return q_t'(lo);
			return q_t'(x);
		endfunction

		function q_t round_clamp(wide_t x);
			return clamp((x + (wide_t'(1) <<< (FB-1))) >>> FB);
		endfunction

		function q_t minor(q_t p0, q_t p1, q_t m0, q_t m1);
			wide_t w0, w1, w2, w3;
			w0 = p0; w1 = p1; w2 = m0; w3 = m1;
			return round_clamp(w0 * w1 - w2 * w3);
		endfunction

		// cofactor scaled by one over the determinant, ties away from zero
		function q_t scaled_div(q_t num, q_t den);
			wide_t sn, sd;
			logic [127:0] mn, md, qt;
			sn = num; sd = den;
			mn = (sn < 0) ? -sn : sn;
			md = (sd < 0) ? -sd : sd;
			qt = ((mn << (FB+1)) + md) / (md << 1);
			if ((sn < 0) != (sd < 0)) return clamp(-wide_t'(qt));
			return clamp(wide_t'(qt));
		endfunction

		function void note(matrix_t m);
			q_t       c[9];
			wide_t    acc, w0, w1, w2, dm;
			inverse_t r;
			for (int k = 0; k < 9; k++)
				c[k] = minor(m.e[CF_P0[k]], m.e[CF_P1[k]], m.e[CF_Q0[k]], m.e[CF_Q1[k]]);
			w0 = m.e[0]; w1 = m.e[1]; w2 = m.e[2];
			acc = w0 * wide_t'(c[0]) + w1 * wide_t'(c[1]) + w2 * wide_t'(c[2]);
			r.det = round_clamp(acc);
			dm = r.det;
			if (dm < 0) dm = -dm;
			r.sing = (r.det == 0) || (dm < wide_t'({1'b0, eps}));
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++)
					r.inv[i*3+j] = r.sing ? q_t'(0) : scaled_div(c[j*3+i], r.det);
			pending.push_back(r);
		endfunction

		function void check(inverse_t got);
			inverse_t want;
			if (pending.size() == 0) begin
				$error("result item with no matrix waiting");
				n_err++;
				return;
			end
			want = pending.pop_front();
			for (int k = 0; k < 9; k++)
				if (got.inv[k] !== want.inv[k]) begin
					$error("inv_r%0dc%0d: expected %0d, got %0d", k/3, k%3,
						want.inv[k], got.inv[k]);
					n_err++;
				end
			if (got.det !== want.det) begin
				$error("determinant: expected %0d, got %0d", want.det, got.det);
				n_err++;
			end
			if (got.sing !== want.sing) begin
				$error("singular: expected %0b, got %0b", want.sing, got.sing);
				n_err++;
			end
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             eps_we = 1'b0;
	logic [EPS_W-1:0] eps_wdata = '0;
	int               idle_cycles = 0;
	logic             hold_off = 1'b0;

	mi3_mat_if #(.DATA_WIDTH(DW)) mat_ch();
	mi3_res_if #(.DATA_WIDTH(DW)) res_ch();

	inverse_scoreboard sb = new();

	matrix3x3_inverse #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.eps_we   (eps_we),
		.eps_wdata(eps_wdata),
		.mat      (mat_ch),
		.res      (res_ch)
	);

	always #4 clk = ~clk;

	initial begin
		mat_ch.valid  = 1'b0;
		mat_ch.a_r0c0 = '0; mat_ch.a_r0c1 = '0; mat_ch.a_r0c2 = '0;
		mat_ch.a_r1c0 = '0; mat_ch.a_r1c1 = '0; mat_ch.a_r1c2 = '0;
		mat_ch.a_r2c0 = '0; mat_ch.a_r2c1 = '0; mat_ch.a_r2c2 = '0;
		res_ch.ready  = 1'b0;
	end

	// Gap length: mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// Note accepted matrices and check accepted results
	always @(posedge clk) begin
		inverse_t got;
		matrix_t  m;
		if (arst_n) begin
			if (mat_ch.valid && mat_ch.ready) begin
				m.e[0] = mat_ch.a_r0c0; m.e[1] = mat_ch.a_r0c1; m.e[2] = mat_ch.a_r0c2;
				m.e[3] = mat_ch.a_r1c0; m.e[4] = mat_ch.a_r1c1; m.e[5] = mat_ch.a_r1c2;
				m.e[6] = mat_ch.a_r2c0; m.e[7] = mat_ch.a_r2c1; m.e[8] = mat_ch.a_r2c2;
				sb.note(m);
			end
			if (res_ch.valid && res_ch.ready) begin
				got.inv[0] = res_ch.inv_r0c0; got.inv[1] = res_ch.inv_r0c1;
				got.inv[2] = res_ch.inv_r0c2; got.inv[3] = res_ch.inv_r1c0;
				got.inv[4] = res_ch.inv_r1c1; got.inv[5] = res_ch.inv_r1c2;
				got.inv[6] = res_ch.inv_r2c0; got.inv[7] = res_ch.inv_r2c1;
				got.inv[8] = res_ch.inv_r2c2;
				got.det    = res_ch.determinant;
				got.sing   = res_ch.singular;
				sb.check(got);
			end
		end
	end

	// Stall the result side at random
	always @(posedge clk) begin
		int stall;
		if (arst_n) begin
			if (hold_off) begin
				hold_off <= 1'b0;
			end else if (res_ch.ready && $urandom_range(0, 3) == 0) begin
				stall = pick_gap();
				if (stall > 0) begin
					res_ch.ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
				res_ch.ready <= 1'b1;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	// Watchdog: cycles with no item moving on either channel
	always @(posedge clk) begin
		if ((mat_ch.valid && mat_ch.ready) || (res_ch.valid && res_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WDOG_MAX) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic write_eps(logic [EPS_W-1:0] v);
		eps_we    <= 1'b1;
		eps_wdata <= v;
		@(posedge clk);
		eps_we    <= 1'b0;
		sb.eps     = v;
	endtask

	// Present one matrix item and hold it until accepted
	task automatic send_matrix(matrix_t m);
		mat_ch.valid  <= 1'b1;
		mat_ch.a_r0c0 <= m.e[0]; mat_ch.a_r0c1 <= m.e[1]; mat_ch.a_r0c2 <= m.e[2];
		mat_ch.a_r1c0 <= m.e[3]; mat_ch.a_r1c1 <= m.e[4]; mat_ch.a_r1c2 <= m.e[5];
		mat_ch.a_r2c0 <= m.e[6]; mat_ch.a_r2c1 <= m.e[7]; mat_ch.a_r2c2 <= m.e[8];
		do @(posedge clk); while (!mat_ch.ready);
	endtask

	task automatic send_with_gap(matrix_t m);
		int g;
		send_matrix(m);
		g = pick_gap();
		if (g > 0) begin
			mat_ch.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	// Drop valid and wait until every expected result has come back
	task automatic drain();
		mat_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (LATENCY + 8) @(posedge clk);
	endtask

	function automatic matrix_t diag(q_t d0, q_t d1, q_t d2);
		matrix_t m;
		foreach (m.e[k]) m.e[k] = '0;
		m.e[0] = d0; m.e[4] = d1; m.e[8] = d2;
		return m;
	endfunction

	function automatic matrix_t fill(q_t v);
		matrix_t m;
		foreach (m.e[k]) m.e[k] = v;
		return m;
	endfunction

	// Random matrix of one of several shapes
	function automatic matrix_t rand_matrix();
		matrix_t m;
		int      shape;
		shape = $urandom_range(0, 9);
		foreach (m.e[k]) begin
			case (shape)
				0, 1: m.e[k] = q_t'($urandom);
				2:    m.e[k] = q_t'($signed($urandom_range(0, 511)) - 256);
				default: m.e[k] = q_t'($signed($urandom_range(0, 20'hFFFFF)) - 32'sd524288);
			endcase
		end
		// near-singular: last row close to the first
		if (shape == 9) begin
			m.e[6] = m.e[0] + q_t'($urandom_range(0, 3));
			m.e[7] = m.e[1];
			m.e[8] = m.e[2] - q_t'($urandom_range(0, 3));
		end
		if (shape == 8) m = diag(q_t'($urandom_range(1, 20'h3FFFF)),
			q_t'(-$signed($urandom_range(1, 20'h3FFFF))), q_t'($urandom_range(1, 20'h3FFFF)));
		return m;
	endfunction

	localparam q_t ONE  = 32'sh0001_0000;
	localparam q_t QMAX = 32'sh7FFF_FFFF;
	localparam q_t QMIN = 32'sh8000_0000;

	initial begin
		matrix_t m;
		logic [EPS_W-1:0] eps_set[5];
		eps_set[0] = EPS_RESET;
		eps_set[1] = '0;
		eps_set[2] = '1;
		eps_set[3] = 31'd65536;
		eps_set[4] = EPS_W'($urandom);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		hold_off <= 1'b1;
		@(posedge clk);

		// Directed corners
		write_eps(EPS_RESET);
		send_with_gap(diag(ONE, ONE, ONE));
		send_with_gap(fill('0));
		send_with_gap(fill(QMAX));
		send_with_gap(fill(QMIN));
		send_with_gap(diag(QMAX, QMAX, QMAX));
		send_with_gap(diag(QMIN, QMIN, QMIN));
		send_with_gap(diag(QMIN, QMAX, QMIN));
		send_with_gap(diag(ONE * 2, -ONE, 32'sh0000_8000));
		send_with_gap(diag(32'sd1, 32'sd1, 32'sd1));
		send_with_gap(diag(ONE, ONE, 32'sd6));
		send_with_gap(diag(ONE, ONE, 32'sd7));
		send_with_gap(diag(ONE, ONE, 32'sd3));
		send_with_gap(diag(32'sh0100_0000, 32'sh0100_0000, 32'sd1));
		m = fill(ONE);
		send_with_gap(m);
		m.e[0] = QMAX; m.e[4] = QMIN; m.e[8] = QMAX; m.e[2] = QMIN;
		send_with_gap(m);
		m = diag(ONE, ONE, ONE);
		m.e[1] = ONE * 3; m.e[5] = -ONE; m.e[6] = ONE * 2;
		send_with_gap(m);
		drain();
		write_eps('0);
		send_with_gap(fill('0));
		send_with_gap(diag(32'sd1, ONE, ONE));
		send_with_gap(diag(ONE, 32'sh0000_0003, 32'sh7FFF_0000));
		drain();

		// Random phases across epsilon settings
		for (int p = 0; p < 5; p++) begin
			write_eps(eps_set[p]);
			for (int n = 0; n < N_RANDOM / 5; n++)
				send_with_gap(rand_matrix());
			drain();
		end

		if (sb.n_err == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
